// ----- rtl/hcrs_pkg.sv -----
// Package for the hit count rank sorter.
// Holds the stored entry type, the sequencer state type and the output load bundle.
// No dependencies; imported by every other file of the block.
package hcrs_pkg;

    localparam int ENTRY_IDX_W = 5;
    localparam int HIT_COUNT_W = 32;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [HIT_COUNT_W-1:0] hit_count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_CMP,
        ST_PLACE,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    typedef struct packed {
        logic   load;
        logic   last;
        entry_t entry;
    } out_load_t;

endpackage

// ----- rtl/hcrs_store.sv -----
// Entry store of the rank sorter: one write port and one read port with registered data.
// Depends on hcrs_pkg for the entry type.
module hcrs_store #(
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  hcrs_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output hcrs_pkg::entry_t rdata
);
    import hcrs_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hcrs_ctrl.sv -----
// Sequencer of the rank sorter: collects entries, runs the insertion ranking with one
// shared comparator over the entry store, and reads the ranked entries out.
// Depends on hcrs_pkg; drives hcrs_store.
module hcrs_ctrl #(
    parameter int  MAX_ENTRIES = 32,
    localparam int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hcrs_pkg::HIT_COUNT_W-1:0]    s_hit_count,
    input  logic                                s_last_item,
    input  logic                                out_free,
    output hcrs_pkg::out_load_t                 out_load,
    output logic                                st_we,
    output logic [AW-1:0]                       st_waddr,
    output hcrs_pkg::entry_t                    st_wdata,
    output logic [AW-1:0]                       st_raddr,
    input  hcrs_pkg::entry_t                    rd_entry
);
    import hcrs_pkg::*;

    localparam int FW = $clog2(MAX_ENTRIES + 1);

    state_t         state_reg, state_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  j_reg, j_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [AW-1:0]  k_reg, k_next;
    entry_t         key_reg, key_next;

    logic           accept;
    logic           full;
    logic [FW-1:0]  fill_inc;
    logic           key_gt;
    logic           sort_done;
    logic           out_done;

    assign accept    = s_valid && s_ready;
    assign full      = (fill_reg == FW'(MAX_ENTRIES));
    assign fill_inc  = full ? fill_reg : fill_reg + FW'(1);
    assign key_gt    = (key_reg.hit_count > rd_entry.hit_count);
    assign sort_done = ((FW'(j_reg) + FW'(1)) == fill_reg);
    assign out_done  = (FW'(k_reg) == (fill_reg - FW'(1)));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (accept && s_last_item) begin
                    state_next = (fill_inc > FW'(1)) ? ST_KEY_RD : ST_OUT_RD;
                end
            end
            ST_KEY_RD: state_next = ST_KEY_LD;
            ST_KEY_LD: state_next = ST_CMP;
            ST_CMP: begin
                if (key_gt) begin
                    state_next = (pos_reg == AW'(1)) ? ST_PLACE : ST_CMP;
                end else begin
                    state_next = sort_done ? ST_OUT_RD : ST_KEY_LD;
                end
            end
            ST_PLACE:  state_next = sort_done ? ST_OUT_RD : ST_KEY_LD;
            ST_OUT_RD: state_next = ST_OUT_LD;
            ST_OUT_LD: begin
                if (out_free) begin
                    state_next = out_done ? ST_FILL : ST_OUT_RD;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        st_we    = 1'b0;
        st_waddr = pos_reg;
        st_wdata = key_reg;
        st_raddr = k_reg;
        out_load = '0;
        case (state_reg)
            ST_FILL: begin
                s_ready  = 1'b1;
                st_we    = accept && !full;
                st_waddr = fill_reg[AW-1:0];
                st_wdata = '{entry_index: ENTRY_IDX_W'(fill_reg), hit_count: s_hit_count};
            end
            ST_KEY_RD: st_raddr = j_reg;
            ST_KEY_LD: st_raddr = j_reg - AW'(1);
            ST_CMP: begin
                st_we = 1'b1;
                if (key_gt) begin
                    st_wdata = rd_entry;
                    st_raddr = pos_reg - AW'(2);
                end else begin
                    st_raddr = j_reg + AW'(1);
                end
            end
            ST_PLACE: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_raddr = j_reg + AW'(1);
            end
            ST_OUT_RD: st_raddr = k_reg;
            ST_OUT_LD: begin
                out_load.load  = out_free;
                out_load.last  = out_done;
                out_load.entry = rd_entry;
            end
            default: st_raddr = k_reg;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        j_next    = j_reg;
        pos_next  = pos_reg;
        k_next    = k_reg;
        key_next  = key_reg;
        case (state_reg)
            ST_FILL: begin
                if (accept) begin
                    fill_next = fill_inc;
                    j_next    = AW'(1);
                    k_next    = '0;
                end
            end
            ST_KEY_LD: begin
                key_next = rd_entry;
                pos_next = j_reg;
            end
            ST_CMP: begin
                if (key_gt) begin
                    pos_next = pos_reg - AW'(1);
                end else if (!sort_done) begin
                    j_next = j_reg + AW'(1);
                end
            end
            ST_PLACE: begin
                if (!sort_done) begin
                    j_next = j_reg + AW'(1);
                end
            end
            ST_OUT_LD: begin
                if (out_free) begin
                    if (out_done) begin
                        fill_next = '0;
                    end else begin
                        k_next = k_reg + AW'(1);
                    end
                end
            end
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg   <= j_next;
        pos_reg <= pos_next;
        k_reg   <= k_next;
        key_reg <= key_next;
    end

`ifndef ASSERT_OFF
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_item) |=> !s_ready)
        else $error("input accepted right after the last beat of a list");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(MAX_ENTRIES))
        else $error("fill level beyond capacity");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (pos_reg != '0) && (pos_reg <= j_reg))
        else $error("insertion position out of range during compare");

    a_list_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load.load && out_load.last) |=> (state_reg == ST_FILL) && (fill_reg == '0))
        else $error("list not cleared after its final result");
`endif

endmodule

// ----- rtl/hit_count_rank_sorter_top.sv -----
// Top level of the hit count rank sorter: sequencer, entry store and output register.
// Depends on hcrs_pkg, hcrs_store and hcrs_ctrl.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_hit_count[31:0], s_last_item
// m_       out  m_valid/m_ready    m_entry_index[4:0], m_ranked_count[31:0], m_last_result
//
// While a list is being collected the input is always ready. A closing beat starts the ranking,
// which uses a single comparator over the one-read, one-write entry store. A list of one entry
// skips the ranking.
// Each result is then read from the store and loaded into the output register once that is free.
// The input is not ready from the closing beat until the final result is in the output register.
// Reset is synchronous and active low; it empties the list and the output register.
module hit_count_rank_sorter_top #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [hcrs_pkg::HIT_COUNT_W-1:0] s_hit_count,
    input  logic                             s_last_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [hcrs_pkg::ENTRY_IDX_W-1:0] m_entry_index,
    output logic [hcrs_pkg::HIT_COUNT_W-1:0] m_ranked_count,
    output logic                             m_last_result
);
    import hcrs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    out_load_t       out_load;
    logic            out_free;
    logic            st_we;
    logic [AW-1:0]   st_waddr;
    entry_t          st_wdata;
    logic [AW-1:0]   st_raddr;
    entry_t          rd_entry;

    logic            m_valid_reg, m_valid_next;
    entry_t          m_entry_reg;
    logic            m_last_reg;

    assign out_free = !m_valid_reg || m_ready;

    hcrs_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_hit_count (s_hit_count),
        .s_last_item (s_last_item),
        .out_free    (out_free),
        .out_load    (out_load),
        .st_we       (st_we),
        .st_waddr    (st_waddr),
        .st_wdata    (st_wdata),
        .st_raddr    (st_raddr),
        .rd_entry    (rd_entry)
    );

    hcrs_store #(
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (rd_entry)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load.load) begin
            m_entry_reg <= out_load.entry;
            m_last_reg  <= out_load.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_index  = m_entry_reg.entry_index;
    assign m_ranked_count = m_entry_reg.hit_count;
    assign m_last_result  = m_last_reg;

endmodule

// ----- bench/hit_count_rank_sorter_top_test.sv -----
// Self-checking bench for the hit count rank sorter: lists of hit counts are streamed in with
// random gaps and the ranked beats are compared with a stable descending sort kept in the bench.
// Depends on hcrs_pkg and hit_count_rank_sorter_top.
`timescale 1ns / 1ps

module hit_count_rank_sorter_top_test;

    import hcrs_pkg::*;

    localparam int MAX_ENTRIES  = 32;
    localparam int RANDOM_ITEMS = 350;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DIR_ROWS     = 20;

    typedef struct {
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [HIT_COUNT_W-1:0] ranked_count;
        logic                   last_result;
    } rank_t;

    typedef struct {
        logic [HIT_COUNT_W-1:0] hit_count;
        logic                   last_item;
        bit                     typed;
        logic [ENTRY_IDX_W-1:0] entry_index;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [HIT_COUNT_W-1:0] s_hit_count = '0;
    logic                   s_last_item = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [ENTRY_IDX_W-1:0] m_entry_index;
    logic [HIT_COUNT_W-1:0] m_ranked_count;
    logic                   m_last_result;

    logic [HIT_COUNT_W-1:0] open_list[$];
    rank_t                  pending_ranks[$];
    int                     errors = 0;
    int                     cycles = 0;
    int                     stall_left = 0;
    bit                     quiet = 1'b0;

    // A typed expectation is only given for a list of one entry.
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 5'd0},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0007, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0000, 1'b0, 1'b0, 5'd0},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0},
        '{32'h0000_0003, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0003, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0003, 1'b1, 1'b0, 5'd0},
        '{32'h0000_0001, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0002, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0003, 1'b0, 1'b0, 5'd0},
        '{32'h0000_0004, 1'b1, 1'b0, 5'd0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 5'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 5'd0},
        '{32'h8000_0000, 1'b0, 1'b0, 5'd0},
        '{32'h7FFF_FFFF, 1'b1, 1'b0, 5'd0},
        '{32'h0000_0001, 1'b1, 1'b1, 5'd0},
        '{32'h8000_0000, 1'b1, 1'b1, 5'd0}
    };

    hit_count_rank_sorter_top #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hit_count   (s_hit_count),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_index (m_entry_index),
        .m_ranked_count(m_ranked_count),
        .m_last_result (m_last_result)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic int pick_idle();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void rank_open_list();
        logic [HIT_COUNT_W-1:0] cnt [MAX_ENTRIES];
        logic [ENTRY_IDX_W-1:0] idx [MAX_ENTRIES];
        logic [HIT_COUNT_W-1:0] key_cnt;
        logic [ENTRY_IDX_W-1:0] key_idx;
        rank_t                  r;
        int                     n;
        int                     pos;
        n = open_list.size();
        for (int k = 0; k < n; k++) begin
            cnt[k] = open_list[k];
            idx[k] = ENTRY_IDX_W'(k);
        end
        for (int j = 1; j < n; j++) begin
            key_cnt = cnt[j];
            key_idx = idx[j];
            pos = j;
            while (pos > 0 && key_cnt > cnt[pos-1]) begin
                cnt[pos] = cnt[pos-1];
                idx[pos] = idx[pos-1];
                pos--;
            end
            cnt[pos] = key_cnt;
            idx[pos] = key_idx;
        end
        for (int k = 0; k < n; k++) begin
            r.entry_index  = idx[k];
            r.ranked_count = cnt[k];
            r.last_result  = (k == n - 1);
            pending_ranks = {pending_ranks, r};
        end
        open_list.delete();
    endfunction

    function automatic void note_beat(input logic [HIT_COUNT_W-1:0] count, input logic last);
        if (open_list.size() < MAX_ENTRIES) begin
            open_list = {open_list, count};
        end
        if (last) begin
            rank_open_list();
        end
    endfunction

    task automatic send_beat(input logic [HIT_COUNT_W-1:0] count, input logic last);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_hit_count <= count;
        s_last_item <= last;
        do @(posedge aclk); while (!s_ready);
        note_beat(count, last);
        @(negedge aclk);
    endtask

    task automatic check_result();
        rank_t want;
        if (pending_ranks.size() == 0) begin
            report_mismatch($sformatf("unexpected beat index %0d count %h last %b",
                                      m_entry_index, m_ranked_count, m_last_result));
            return;
        end
        want = pending_ranks.pop_front();
        if (m_entry_index !== want.entry_index) begin
            report_mismatch($sformatf("entry_index %0d, expected %0d",
                                      m_entry_index, want.entry_index));
        end
        if (m_ranked_count !== want.ranked_count) begin
            report_mismatch($sformatf("ranked_count %h, expected %h",
                                      m_ranked_count, want.ranked_count));
        end
        if (m_last_result !== want.last_result) begin
            report_mismatch($sformatf("last_result %b, expected %b",
                                      m_last_result, want.last_result));
        end
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result();
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            m_ready <= 1'b0;
            stall_left <= pick_idle();
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int                     sent;
        int                     len;
        int                     mode;
        int                     r;
        logic [HIT_COUNT_W-1:0] count;
        rank_t                  typed_rank;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(directed_rows[i].hit_count, directed_rows[i].last_item);
            if (directed_rows[i].typed) begin
                typed_rank.entry_index  = directed_rows[i].entry_index;
                typed_rank.ranked_count = directed_rows[i].hit_count;
                typed_rank.last_result  = 1'b1;
                void'(pending_ranks.pop_back());
                pending_ranks = {pending_ranks, typed_rank};
            end
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = $urandom_range(1, 6);
            end else if (r < 90) begin
                len = $urandom_range(7, 31);
            end else begin
                len = $urandom_range(MAX_ENTRIES, MAX_ENTRIES + 8);
            end
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: begin
                        count = $urandom;
                    end
                    1: begin
                        count = $urandom_range(0, 3);
                    end
                    default: begin
                        r = $urandom_range(0, 2);
                        count = (r == 0) ? '0 : (r == 1) ? '1 : HIT_COUNT_W'($urandom);
                    end
                endcase
                send_beat(count, k == len - 1);
            end
            sent += (len > MAX_ENTRIES) ? MAX_ENTRIES + 1 : len;
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_ranks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
